/* rtl/core/hbr_pkg.sv */
// Package for the HTTP byte range parser: parse phases, form codes,
// answer codes and the unit text. No dependencies.
package hbr_pkg;

  typedef enum logic [3:0] {
    PH_LEAD       = 4'd0,
    PH_PREFIX     = 4'd1,
    PH_GAP        = 4'd2,
    PH_SUF_START  = 4'd3,
    PH_SUF_DIGITS = 4'd4,
    PH_FIRST      = 4'd5,
    PH_DASH       = 4'd6,
    PH_LAST       = 4'd7,
    PH_TAIL       = 4'd8,
    PH_FAIL       = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    FORM_NONE   = 2'd0,
    FORM_SUFFIX = 2'd1,
    FORM_OPEN   = 2'd2,
    FORM_CLOSED = 2'd3
  } form_t;

  localparam logic [1:0] ANS_WHOLE   = 2'd0;
  localparam logic [1:0] ANS_UNSAT   = 2'd1;
  localparam logic [1:0] ANS_PARTIAL = 2'd2;

  localparam int          UNIT_LEN  = 6;
  localparam logic [2:0]  UNIT_LAST = 3'(UNIT_LEN - 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Lower-case unit text "bytes=", one character per index.
  function automatic logic [7:0] unit_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h62;  // b
      3'd1:    c = 8'h79;  // y
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h73;  // s
      3'd5:    c = 8'h3D;  // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/http_byte_range_parser.sv */
// Top level of the HTTP byte range parser: input register, character
// parser with one shared decimal accumulator, verdict logic, result register.
// Depends on hbr_pkg.

// The block takes an HTTP Range header one character per transfer (mode 0)
// and then an end transfer (mode 1) carrying the resource length; each end
// transfer yields exactly one result: whole, unsatisfiable, or partial with
// first and last byte offsets (last inclusive, clipped to length-1). Character
// transfers yield no result. Items are taken one per cycle while in_stall is
// low; each is held in an input register, worked by a single pass of logic
// (one multiply-by-ten and add for digits, 64-bit compares and two subtracts
// for the verdict) and, for an end item, moved from there into the result
// register once it is free, and the result is taken from that register.
// in_stall rises only when an end item sits in the input register while the
// result register still holds an untaken result; while it is high no
// transfer is taken, and a character item in the input register never waits.
// After every end item the parser returns to its reset state, ready for the next header.
module http_byte_range_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  header_char,
  input  logic [63:0] resource_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  answer,
  output logic [63:0] first_byte,
  output logic [63:0] last_byte
);
  import hbr_pkg::*;

  // Input register
  logic        s1_valid;
  logic        s1_mode;
  logic [7:0]  s1_char;
  logic [63:0] s1_len;
  logic        s1_adv;

  // Parser state
  phase_t      phase, phase_next;
  logic [2:0]  prefix_index, prefix_index_next;
  logic [63:0] first_value, first_value_next;
  logic [63:0] second_value, second_value_next;
  form_t       form, form_next;
  logic        junk, junk_next;
  logic        error, error_next;

  // Character decode
  logic        is_blank;
  logic        is_digit;
  logic [7:0]  low_char;
  logic [3:0]  digit;

  // Shared decimal accumulator: acc*10 + digit, 4 guard bits catch overflow
  logic        mac_second;
  logic [63:0] mac_src;
  logic [67:0] mac_sum;
  logic        mac_ovf;

  // Verdict
  logic [1:0]  ans_c;
  logic [63:0] first_c, last_c;
  form_t       eff_form;
  logic        len_zero, suf_zero, second_lt_first, first_ge_len, second_ge_len;
  logic        phase_done;
  logic [63:0] len_minus_first, len_minus_one;

  logic        out_load;

  // Hold an end item while the result register is full and stalled.
  assign s1_adv   = !(s1_valid && s1_mode && out_valid && out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign out_load = s1_valid && s1_mode && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_mode <= mode;
      s1_char <= header_char;
      s1_len  <= resource_length;
    end
  end

  assign is_blank = (s1_char == CH_SPACE) || (s1_char == CH_TAB);
  assign is_digit = (s1_char >= CH_ZERO) && (s1_char <= CH_NINE);
  assign low_char = ((s1_char >= CH_UPPER_A) && (s1_char <= CH_UPPER_Z)) ?
                    (s1_char | CASE_BIT) : s1_char;
  assign digit    = s1_char[3:0];

  // The second number is only ever built in the dash and last phases.
  assign mac_second = (phase == PH_DASH) || (phase == PH_LAST);
  assign mac_src    = mac_second ? second_value : first_value;
  assign mac_sum    = ({4'b0, mac_src} << 3) + ({4'b0, mac_src} << 1) + {64'b0, digit};
  assign mac_ovf    = |mac_sum[67:64];

  // Next state for one character.
  always_comb begin
    phase_next        = phase;
    prefix_index_next = prefix_index;
    first_value_next  = first_value;
    second_value_next = second_value;
    form_next         = form;
    junk_next         = junk;
    error_next        = error;
    unique case (phase)
      PH_LEAD: begin
        if (!is_blank) begin
          // Fall into prefix matching at index zero.
          if (low_char != unit_char(3'd0)) begin
            phase_next = PH_FAIL;
            error_next = 1'b1;
          end else begin
            phase_next        = PH_PREFIX;
            prefix_index_next = 3'd1;
          end
        end
      end
      PH_PREFIX: begin
        if (prefix_index > UNIT_LAST || low_char != unit_char(prefix_index)) begin
          phase_next = PH_FAIL;
          error_next = 1'b1;
        end else begin
          prefix_index_next = prefix_index + 3'd1;
          if (prefix_index == UNIT_LAST) begin
            phase_next = PH_GAP;
          end
        end
      end
      PH_GAP: begin
        if (is_blank) begin
          phase_next = PH_GAP;
        end else if (s1_char == CH_DASH) begin
          phase_next = PH_SUF_START;
        end else if (is_digit) begin
          if (mac_ovf) begin
            phase_next = PH_FAIL;
            error_next = 1'b1;
          end else begin
            phase_next       = PH_FIRST;
            first_value_next = mac_sum[63:0];
          end
        end else begin
          phase_next = PH_FAIL;
          error_next = 1'b1;
        end
      end
      PH_SUF_START: begin
        if (!is_digit) begin
          phase_next = PH_FAIL;
          error_next = 1'b1;
        end else begin
          form_next = FORM_SUFFIX;
          if (mac_ovf) begin
            phase_next = PH_FAIL;
            error_next = 1'b1;
          end else begin
            phase_next       = PH_SUF_DIGITS;
            first_value_next = mac_sum[63:0];
          end
        end
      end
      PH_SUF_DIGITS, PH_LAST: begin
        if (is_digit) begin
          if (mac_ovf) begin
            phase_next = PH_FAIL;
            error_next = 1'b1;
          end else if (mac_second) begin
            second_value_next = mac_sum[63:0];
          end else begin
            first_value_next = mac_sum[63:0];
          end
        end else begin
          phase_next = PH_TAIL;
          junk_next  = !is_blank;
        end
      end
      PH_FIRST: begin
        if (is_digit) begin
          if (mac_ovf) begin
            phase_next = PH_FAIL;
            error_next = 1'b1;
          end else begin
            first_value_next = mac_sum[63:0];
          end
        end else if (s1_char == CH_DASH) begin
          phase_next = PH_DASH;
        end else begin
          phase_next = PH_FAIL;
          error_next = 1'b1;
        end
      end
      PH_DASH: begin
        if (is_digit) begin
          form_next = FORM_CLOSED;
          if (mac_ovf) begin
            phase_next = PH_FAIL;
            error_next = 1'b1;
          end else begin
            phase_next        = PH_LAST;
            second_value_next = mac_sum[63:0];
          end
        end else begin
          form_next  = FORM_OPEN;
          phase_next = PH_TAIL;
          junk_next  = junk || !is_blank;
        end
      end
      PH_TAIL: begin
        junk_next = junk || !is_blank;
      end
      default: begin
        phase_next = PH_FAIL;
        error_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      prefix_index <= 3'd0;
      first_value  <= 64'd0;
      second_value <= 64'd0;
      form         <= FORM_NONE;
      junk         <= 1'b0;
      error        <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      if (s1_mode) begin
        // End item consumed: start over for the next header.
        phase        <= PH_LEAD;
        prefix_index <= 3'd0;
        first_value  <= 64'd0;
        second_value <= 64'd0;
        form         <= FORM_NONE;
        junk         <= 1'b0;
        error        <= 1'b0;
      end else begin
        phase        <= phase_next;
        prefix_index <= prefix_index_next;
        first_value  <= first_value_next;
        second_value <= second_value_next;
        form         <= form_next;
        junk         <= junk_next;
        error        <= error_next;
      end
    end
  end

  // Verdict for an end item.
  assign eff_form        = (phase == PH_DASH) ? FORM_OPEN : form;
  assign phase_done      = (phase == PH_SUF_DIGITS) || (phase == PH_DASH) ||
                           (phase == PH_LAST) || (phase == PH_TAIL);
  assign len_zero        = (s1_len == 64'd0);
  assign suf_zero        = (first_value == 64'd0);
  assign second_lt_first = (second_value < first_value);
  assign first_ge_len    = (first_value >= s1_len);
  assign second_ge_len   = (second_value >= s1_len);
  assign len_minus_first = s1_len - first_value;
  assign len_minus_one   = s1_len - 64'd1;

  always_comb begin
    ans_c   = ANS_WHOLE;
    first_c = 64'd0;
    last_c  = 64'd0;
    priority if (error || !phase_done) begin
      ans_c = ANS_WHOLE;
    end else if (eff_form == FORM_SUFFIX) begin
      // Zero suffix or zero length refuses before trailing text counts.
      if (suf_zero || len_zero) begin
        ans_c = ANS_UNSAT;
      end else if (junk) begin
        ans_c = ANS_WHOLE;
      end else begin
        ans_c   = ANS_PARTIAL;
        first_c = first_ge_len ? 64'd0 : len_minus_first;
        last_c  = len_minus_one;
      end
    end else if (eff_form == FORM_NONE) begin
      ans_c = ANS_WHOLE;
    end else if (eff_form == FORM_CLOSED && second_lt_first) begin
      ans_c = ANS_WHOLE;
    end else if (junk) begin
      ans_c = ANS_WHOLE;
    end else if (len_zero || first_ge_len) begin
      ans_c = ANS_UNSAT;
    end else begin
      ans_c   = ANS_PARTIAL;
      first_c = first_value;
      last_c  = (eff_form == FORM_OPEN || second_ge_len) ? len_minus_one : second_value;
    end
  end

  // Result register: load on an end item, drop once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      answer     <= ans_c;
      first_byte <= first_c;
      last_byte  <= last_c;
    end
  end

  // Checks
  a_answer_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (answer == ANS_WHOLE || answer == ANS_UNSAT || answer == ANS_PARTIAL))
    else $error("answer code out of range");

  a_zero_unless_partial: assert property (@(posedge clk) disable iff (rst)
    (out_valid && answer != ANS_PARTIAL) |-> (first_byte == 64'd0 && last_byte == 64'd0))
    else $error("offsets not zero on a non-partial answer");

  a_partial_ordered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && answer == ANS_PARTIAL) |-> (first_byte <= last_byte))
    else $error("partial range with first beyond last");

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (phase == PH_LEAD && prefix_index == 3'd0 && !error && !junk))
    else $error("parser not back at leading phase after end item");

endmodule

/* dv/tb_http_byte_range_parser.sv */
// Self-checking testbench for http_byte_range_parser: directed and random Range headers,
// a queue-fed driver, a stalling result monitor and an in-bench predictor of the verdicts.
// Depends on hbr_pkg and the http_byte_range_parser RTL.
module tb_http_byte_range_parser;
  import hbr_pkg::*;

  localparam logic [63:0] LEN_MAX     = '1;
  localparam logic [47:0] UNIT_WORD   = "bytes=";
  localparam int          RAND_ITEMS  = 620;
  localparam int          DRAIN_LIMIT = 2000;
  localparam int          SETTLE      = 20;

  typedef struct {
    logic        is_end;
    logic [7:0]  ch;
    logic [63:0] len;
  } header_item_t;

  typedef struct packed {
    logic [1:0]  answer;
    logic [63:0] lo;
    logic [63:0] hi;
  } range_verdict_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [7:0]  header_char = 8'd0;
  logic [63:0] resource_length = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  answer;
  logic [63:0] first_byte;
  logic [63:0] last_byte;

  http_byte_range_parser uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .header_char     (header_char),
    .resource_length (resource_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .answer          (answer),
    .first_byte      (first_byte),
    .last_byte       (last_byte)
  );

  header_item_t   pending_items[$];
  range_verdict_t verdicts_due[$];
  logic [7:0]     hdr_text[$];

  int mismatches   = 0;
  int chars_sent   = 0;
  int headers_sent = 0;
  int n_whole      = 0;
  int n_unsat      = 0;
  int n_partial    = 0;

  // Parser shadow state, updated once per accepted transfer.
  phase_t      ps         = PH_LEAD;
  logic [2:0]  unit_pos   = '0;
  logic [63:0] off_a      = '0;
  logic [63:0] off_b      = '0;
  form_t       shape      = FORM_NONE;
  logic        junk_seen  = 1'b0;
  logic        header_bad = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic mark_bad();
    ps = PH_FAIL;
    header_bad = 1'b1;
  endtask

  // Append one decimal digit; anything past 2^64-1 poisons the header.
  task automatic push_digit(inout logic [63:0] acc, input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - CH_ZERO);
    if (acc > (LEN_MAX - d) / 64'd10) mark_bad();
    else acc = acc * 64'd10 + d;
  endtask

  task automatic enter_tail(input logic [7:0] c);
    ps = PH_TAIL;
    if (!is_blank(c)) junk_seen = 1'b1;
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [7:0] low;
    low = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_BIT) : c;
    // First non-blank character starts the unit match.
    if (ps == PH_LEAD && !is_blank(c)) begin
      ps = PH_PREFIX;
      unit_pos = '0;
    end
    case (ps)
      PH_LEAD: ;
      PH_PREFIX: begin
        if (unit_pos > UNIT_LAST || low != UNIT_WORD[8*(UNIT_LAST - unit_pos) +: 8]) begin
          mark_bad();
        end else begin
          unit_pos = unit_pos + 3'd1;
          if (unit_pos == 3'(UNIT_LEN)) ps = PH_GAP;
        end
      end
      PH_GAP: begin
        if (is_blank(c)) ;
        else if (c == CH_DASH) ps = PH_SUF_START;
        else if (is_digit(c)) begin
          ps = PH_FIRST;
          push_digit(off_a, c);
        end else mark_bad();
      end
      PH_SUF_START: begin
        if (!is_digit(c)) mark_bad();
        else begin
          ps = PH_SUF_DIGITS;
          shape = FORM_SUFFIX;
          push_digit(off_a, c);
        end
      end
      PH_SUF_DIGITS: begin
        if (is_digit(c)) push_digit(off_a, c);
        else enter_tail(c);
      end
      PH_FIRST: begin
        if (is_digit(c)) push_digit(off_a, c);
        else if (c == CH_DASH) ps = PH_DASH;
        else mark_bad();
      end
      PH_DASH: begin
        if (is_digit(c)) begin
          ps = PH_LAST;
          shape = FORM_CLOSED;
          push_digit(off_b, c);
        end else begin
          shape = FORM_OPEN;
          enter_tail(c);
        end
      end
      PH_LAST: begin
        if (is_digit(c)) push_digit(off_b, c);
        else enter_tail(c);
      end
      PH_TAIL: begin
        if (!is_blank(c)) junk_seen = 1'b1;
      end
      default: mark_bad();
    endcase
  endtask

  // Work out the verdict for the end transfer, then return to the idle state.
  task automatic close_header(input logic [63:0] len, output range_verdict_t v);
    logic complete;
    v = '0;
    v.answer = ANS_WHOLE;
    if (ps == PH_DASH) shape = FORM_OPEN;
    complete = ps == PH_SUF_DIGITS || ps == PH_DASH || ps == PH_LAST || ps == PH_TAIL;
    if (header_bad || !complete) begin
      v.answer = ANS_WHOLE;
    end else if (shape == FORM_SUFFIX) begin
      // Zero suffix or zero length refuses even with trailing junk.
      if (off_a == 64'd0 || len == 64'd0) v.answer = ANS_UNSAT;
      else if (!junk_seen) begin
        v.answer = ANS_PARTIAL;
        v.lo     = (off_a >= len) ? 64'd0 : len - off_a;
        v.hi     = len - 64'd1;
      end
    end else if (shape == FORM_NONE || (shape == FORM_CLOSED && off_b < off_a) || junk_seen) begin
      v.answer = ANS_WHOLE;
    end else if (len == 64'd0 || off_a >= len) begin
      v.answer = ANS_UNSAT;
    end else begin
      v.answer = ANS_PARTIAL;
      v.lo     = off_a;
      v.hi     = (shape == FORM_OPEN || off_b >= len) ? len - 64'd1 : off_b;
    end
    ps         = PH_LEAD;
    unit_pos   = '0;
    off_a      = '0;
    off_b      = '0;
    shape      = FORM_NONE;
    junk_seen  = 1'b0;
    header_bad = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Header builders
  // ---------------------------------------------------------------------------
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr_text.push_back(s[i]);
  endtask

  task automatic add_number(input logic [63:0] v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(CH_ZERO + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 64'd0);
    foreach (digs[i]) hdr_text.push_back(digs[i]);
  endtask

  // Mostly a plain number; now and then a leading zero or a value past 2^64-1.
  task automatic add_number_mixed(input logic [63:0] v);
    if ($urandom_range(0, 15) == 0) begin
      if ($urandom_range(0, 1) == 1) add_text("18446744073709551616");
      else add_text("99999999999999999999999");
    end else begin
      if ($urandom_range(0, 7) == 0) hdr_text.push_back(CH_ZERO);
      add_number(v);
    end
  endtask

  task automatic add_blanks(input int n);
    repeat (n) hdr_text.push_back(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_TAB);
  endtask

  // Unit text with each letter's case flipped at random.
  task automatic add_unit();
    logic [7:0] c;
    for (int i = 0; i < UNIT_LEN; i++) begin
      c = UNIT_WORD[8*(UNIT_LEN - 1 - i) +: 8];
      if (c != 8'h3D && $urandom_range(0, 1) == 1) c = c ^ CASE_BIT;
      hdr_text.push_back(c);
    end
  endtask

  // Queue the built text as character transfers, then the end transfer.
  task automatic emit_header(input logic [63:0] len);
    header_item_t it;
    foreach (hdr_text[i]) begin
      it.is_end = 1'b0;
      it.ch     = hdr_text[i];
      it.len    = {$urandom, $urandom};
      pending_items.push_back(it);
    end
    it.is_end = 1'b1;
    it.ch     = 8'($urandom_range(0, 255));
    it.len    = len;
    pending_items.push_back(it);
    hdr_text.delete();
  endtask

  task automatic directed(input string s, input logic [63:0] len);
    add_text(s);
    emit_header(len);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 6))
      0:       return 64'($urandom_range(0, 20));
      1:       return 64'($urandom_range(0, 5000));
      2:       return 64'($urandom);
      3:       return {$urandom, $urandom};
      4:       return LEN_MAX - 64'($urandom_range(0, 3));
      5:       return 64'd1 << $urandom_range(0, 63);
      default: return 64'($urandom_range(0, 1000000));
    endcase
  endfunction

  // Lengths near the parsed offset hit the boundaries of each verdict.
  function automatic logic [63:0] pick_length(input logic [63:0] near);
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return near;
      2:       return near + 64'd1;
      3:       return near + 64'($urandom_range(1, 100));
      4:       return near - 64'($urandom_range(0, 3));
      5:       return LEN_MAX;
      default: return pick_value();
    endcase
  endfunction

  task automatic random_header();
    int          kind;
    int          cut;
    logic [63:0] a;
    logic [63:0] b;
    string       charset;
    kind    = $urandom_range(0, 9);
    charset = "bytes=-0123456789 \tBYTES";
    a       = pick_value();
    b       = ($urandom_range(0, 1) == 1) ? a + 64'($urandom_range(0, 50)) : pick_value();
    if (kind == 9) begin
      // Noise: short runs of arbitrary bytes mixed with header-like ones.
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 1) == 1) hdr_text.push_back(8'($urandom_range(0, 255)));
        else hdr_text.push_back(charset[$urandom_range(0, charset.len() - 1)]);
      end
      emit_header(pick_value());
    end else begin
      if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 2));
      add_unit();
      if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 2));
      case ($urandom_range(0, 2))
        0: begin
          add_number_mixed(a);
          hdr_text.push_back(CH_DASH);
          add_number_mixed(b);
        end
        1: begin
          add_number_mixed(a);
          hdr_text.push_back(CH_DASH);
        end
        default: begin
          hdr_text.push_back(CH_DASH);
          add_number_mixed(a);
        end
      endcase
      if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 3));
      if ($urandom_range(0, 7) == 0) hdr_text.push_back(8'($urandom_range(0, 255)));
      // Broken sequence: cut short or one byte overwritten.
      if (kind == 8 && hdr_text.size() > 0) begin
        cut = $urandom_range(0, hdr_text.size() - 1);
        if ($urandom_range(0, 1) == 1) begin
          while (hdr_text.size() > cut) void'(hdr_text.pop_back());
        end else begin
          hdr_text[cut] = 8'($urandom_range(0, 255));
        end
      end
      emit_header(pick_length(a));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pop pending transfers, predict on acceptance, idle at random between items
  // ---------------------------------------------------------------------------
  int   in_gap  = 0;
  logic in_calm = 1'b0;

  always @(posedge clk) begin : drive_items
    int             gap;
    header_item_t   it;
    range_verdict_t v;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        // Transfer taken: advance the predictor with what was on the ports.
        if (mode) begin
          close_header(resource_length, v);
          verdicts_due.push_back(v);
          headers_sent++;
          in_calm <= ($urandom_range(0, 3) == 0);
        end else begin
          parse_char(header_char);
          chars_sent++;
        end
        gap = in_calm ? 0 : $urandom_range(0, 8);
        if (gap == 0 && pending_items.size() > 0) begin
          // Keep valid high and present the next item back to back.
          it = pending_items.pop_front();
          mode            <= it.is_end;
          header_char     <= it.ch;
          resource_length <= it.len;
        end else begin
          in_valid <= 1'b0;
          in_gap   <= (gap == 0) ? 0 : gap - 1;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          mode            <= it.is_end;
          header_char     <= it.ch;
          resource_length <= it.len;
          in_valid        <= 1'b1;
        end
      end
      // A stalled transfer holds its payload untouched.
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result with the oldest verdict, stall at random
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  logic out_calm   = 1'b0;

  always @(posedge clk) begin : check_results
    int             k;
    range_verdict_t want;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("result with nothing pending, answer", 64'(answer), 64'd0);
        end else begin
          want = verdicts_due.pop_front();
          if (answer !== want.answer)
            report_mismatch("answer", 64'(answer), 64'(want.answer));
          if (first_byte !== want.lo) report_mismatch("first_byte", first_byte, want.lo);
          if (last_byte !== want.hi) report_mismatch("last_byte", last_byte, want.hi);
          case (want.answer)
            ANS_WHOLE: n_whole++;
            ANS_UNSAT: n_unsat++;
            default:   n_partial++;
          endcase
        end
        // Hold off the next result; the stall spans idle time too, so an end
        // item may arrive while the result register is still full.
        k = out_calm ? 0 : $urandom_range(0, 8);
        out_calm <= ($urandom_range(0, 3) == 0);
        if (k > 0) begin
          out_stall  <= 1'b1;
          stall_left <= k - 1;
        end
      end else if (out_stall) begin
        // Count down only while a result is waiting.
        if (stall_left == 0) out_stall <= 1'b0;
        else if (out_valid) stall_left <= stall_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int base;
    int spins;
    // Directed headers: each form, each refusal and each fallback to whole.
    directed("bytes=0-0", 64'd1);
    directed("Bytes=0-499", 64'd1000);
    directed("  \tBYTES= 500-", 64'd1000);
    directed("bytes=5-\t ", 64'd6);
    directed("bytes=-500", 64'd1000);
    directed("bYtEs=-2000", 64'd1000);
    directed("bytes=-0", 64'd100);
    directed("bytes=-5 x", 64'd0);
    directed("bytes=-0junk", 64'd50);
    directed("bytes=5-1", 64'd10);
    directed("bytes=18446744073709551615-", LEN_MAX);
    directed("bytes=18446744073709551616-", LEN_MAX);
    directed("bytes=0-18446744073709551615", LEN_MAX);
    directed("bytes=-18446744073709551615 ", LEN_MAX);
    directed("bytes=10-20", 64'd0);
    directed("bytes=10-20 \t", 64'd15);
    directed("bytes=10-20x", 64'd100);
    directed("bytes=", 64'd10);
    directed("bytes=-", 64'd10);
    directed("bytes=5", 64'd10);
    directed("bytez=0-1", 64'd10);
    directed("bytes=abc", 64'd10);
    directed("", 64'd10);
    add_text("bytes=1-2");
    hdr_text.push_back(8'hFF);
    emit_header(64'd100);
    directed("bytes=7-", 64'd7);

    base = pending_items.size();
    while (pending_items.size() < base + RAND_ITEMS) random_header();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to be taken, then for the last results to land.
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    spins = 0;
    while (verdicts_due.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE) @(posedge clk);
    foreach (verdicts_due[i])
      report_mismatch("missing result, answer", 64'hX, 64'(verdicts_due[i].answer));

    $display("Sent %0d headers as %0d character transfers plus end transfers.",
             headers_sent, chars_sent);
    $display("Verdicts checked: %0d whole, %0d unsatisfiable, %0d partial; %0d mismatches.",
             n_whole, n_unsat, n_partial, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("Timed out waiting for transfers to complete.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
